// ----- hdl/rdmc_pkg.sv -----
// Shared types, sizes and helper functions for the maze carver.
// Used by every module of the carver; depends on nothing else.
`timescale 1ns / 1ps

package rdmc_pkg;

   // grid limits
   localparam int MAX_ROWS    = 64;
   localparam int MAX_COLS    = 64;
   localparam int CELL_COUNT  = MAX_ROWS * MAX_COLS;
   localparam int ROW_W       = $clog2(MAX_ROWS);
   localparam int COL_W       = $clog2(MAX_COLS);
   localparam int CELL_W      = ROW_W + COL_W;
   localparam int DEPTH_W     = $clog2(CELL_COUNT + 1);
   localparam int COORD_MAX_W = (ROW_W > COL_W) ? ROW_W : COL_W;

   // field widths
   localparam int CFG_W       = 7;
   localparam int SIZE_W      = (COORD_MAX_W + 1 > CFG_W) ? COORD_MAX_W + 1 : CFG_W;
   localparam int RND_W       = 16;
   localparam int OUT_COORD_W = 6;
   localparam int DIR_W       = 2;
   localparam int RSP_FIELD_W = 2 * OUT_COORD_W + DIR_W;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // opcodes
   localparam logic OP_STEP    = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   // register indexes (address bit 2)
   localparam logic REG_ROWS = 1'b0;
   localparam logic REG_COLS = 1'b1;

   localparam logic [CFG_W-1:0] ROWS_RESET = CFG_W'(8);
   localparam logic [CFG_W-1:0] COLS_RESET = CFG_W'(8);

   typedef enum logic [DIR_W-1:0] {
      DIR_NORTH = 2'd0,
      DIR_SOUTH = 2'd1,
      DIR_WEST  = 2'd2,
      DIR_EAST  = 2'd3
   } dir_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_TOP,
      ST_NBR,
      ST_EVAL,
      ST_COMMIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic accept;    // latch item, reset per-item state
      logic rd_top;    // read stack top
      logic rd_nbr;    // latch top cell, read north and south rows
      logic rd_cur;    // latch neighbor rows, read the cell's own row
      logic eval;      // pick direction, build row write data
      logic commit;    // push or pop, write visited row
      logic clr_step;  // clear one visited row
      logic out_load;  // move result into the output register
   } cmd_type;

   typedef struct packed {
      logic stack_empty;
      logic clr_last;
      logic out_free;
   } status_type;

   // register value 0 counts as 1, above the limit counts as the limit
   function automatic logic [SIZE_W-1:0] used_size(input logic [CFG_W-1:0] reg_v,
                                                   input int limit);
      logic [SIZE_W-1:0] v;
      v = SIZE_W'(reg_v);
      if (v == '0)
         return SIZE_W'(1);
      if (v > SIZE_W'(limit))
         return SIZE_W'(limit);
      return v;
   endfunction

   // 4 and 16 are both 1 mod 3, so digit sums fold the value down
   function automatic logic [1:0] mod3_16(input logic [RND_W-1:0] v);
      logic [4:0] s1;
      logic [2:0] s2;
      logic [2:0] s3;
      logic [1:0] res;
      s1 = '0;
      for (int i = 0; i < RND_W / 2; i++)
         s1 = s1 + 5'(v[2*i +: 2]);
      s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
      s3 = 3'(s2[1:0]) + 3'(s2[2]);
      case (s3)
         3'd3:    res = 2'd0;
         3'd4:    res = 2'd1;
         default: res = s3[1:0];
      endcase
      return res;
   endfunction

   // k-th set bit of the candidate mask, north first
   function automatic dir_type pick_dir(input logic [3:0] mask, input logic [1:0] k);
      logic [1:0] seen;
      dir_type    d;
      seen = '0;
      d    = DIR_NORTH;
      for (int i = 0; i < 4; i++) begin
         if (mask[i]) begin
            if (seen == k)
               d = dir_type'(2'(i));
            seen = seen + 2'd1;
         end
      end
      return d;
   endfunction

endpackage

// ----- hdl/random_dfs_maze_carver_core.sv -----
// Top level of the randomized depth-first maze carver.
// Depends on rdmc_pkg, rdmc_csr, rdmc_ctrl and rdmc_datapath.
//
// Each input item gives exactly one result item. A step item goes through
// one stack read, two rounds of visited-map reads (three rows over a
// two-read-port row memory), evaluation, commit and the hand-off to the
// output register. A step on an empty stack goes straight to the hand-off.
// A restart clears all MAX_ROWS rows of the visited map one row per cycle;
// no item is taken during that pass. The stack is empty after reset, so a
// restart is needed before carving. A finished result waits in the output
// register while the next item is accepted. Grid size registers are written
// over the APB port at byte address 0 (rows) and 4 (columns); the user must
// write them only while the block is idle. The block does not enforce this.
`timescale 1ns / 1ps

module random_dfs_maze_carver_core
   import rdmc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // input items
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [RND_W-1:0]      req_tdata,   // [15:0] random_value
   input  logic                  req_tuser,   // [0] opcode
   // result items
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [5:0] cell_row, [11:6] cell_col,
                                              // [13:12] direction, [15:14] zero
   output logic                  rsp_tuser,   // [0] carved
   output logic                  rsp_tlast,   // finished
   // configuration
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cmd_type                cmd;
   status_type             status;
   logic [CFG_W-1:0]       grid_rows;
   logic [CFG_W-1:0]       grid_cols;
   logic [OUT_COORD_W-1:0] cell_row;
   logic [OUT_COORD_W-1:0] cell_col;
   logic [DIR_W-1:0]       direction;

   rdmc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .grid_rows   (grid_rows),
      .grid_cols   (grid_cols)
   );

   rdmc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_opcode (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rdmc_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_random_value (req_tdata),
      .grid_rows        (grid_rows),
      .grid_cols        (grid_cols),
      .rsp_tready       (rsp_tready),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_carved       (rsp_tuser),
      .rsp_cell_row     (cell_row),
      .rsp_cell_col     (cell_col),
      .rsp_direction    (direction),
      .rsp_finished     (rsp_tlast)
   );

   assign rsp_tdata = RSP_DATA_W'({direction, cell_col, cell_row});

endmodule

// ----- hdl/rdmc_csr.sv -----
// Configuration registers (grid rows and columns) behind an APB-style port.
// Depends on rdmc_pkg.
`timescale 1ns / 1ps

module rdmc_csr
   import rdmc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [CFG_W-1:0]      grid_rows,
   output logic [CFG_W-1:0]      grid_cols
);

   logic [CFG_W-1:0] rows_ff, rows_in;
   logic [CFG_W-1:0] cols_ff, cols_in;
   logic             wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (wr_en) begin
         if (csr_paddr[2] == REG_ROWS)
            rows_in = csr_pwdata[CFG_W-1:0];
         else
            cols_in = csr_pwdata[CFG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= ROWS_RESET;
         cols_ff <= COLS_RESET;
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   always_comb begin
      if (csr_paddr[2] == REG_COLS)
         csr_prdata = CSR_DATA_W'(cols_ff);
      else
         csr_prdata = CSR_DATA_W'(rows_ff);
   end

   assign grid_rows = rows_ff;
   assign grid_cols = cols_ff;

endmodule

// ----- hdl/rdmc_ctrl.sv -----
// Sequencer: steps each item through stack read, row reads, evaluation,
// commit and result hand-off, or row clearing for a restart. Uses rdmc_pkg.
`timescale 1ns / 1ps

module rdmc_ctrl
   import rdmc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_opcode,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_opcode == OP_RESTART)
                  state_in = ST_CLEAR;
               else if (status.stack_empty)
                  state_in = ST_OUT;
               else
                  state_in = ST_TOP;
            end
         end
         ST_CLEAR: begin
            if (status.clr_last)
               state_in = ST_OUT;
         end
         ST_TOP:    state_in = ST_NBR;
         ST_NBR:    state_in = ST_EVAL;
         ST_EVAL:   state_in = ST_COMMIT;
         ST_COMMIT: state_in = ST_OUT;
         ST_OUT: begin
            if (status.out_free)
               state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
            cmd.rd_top = req_tvalid && (req_opcode == OP_STEP) && !status.stack_empty;
         end
         ST_CLEAR:  cmd.clr_step = 1'b1;
         ST_TOP:    cmd.rd_nbr   = 1'b1;
         ST_NBR:    cmd.rd_cur   = 1'b1;
         ST_EVAL:   cmd.eval     = 1'b1;
         ST_COMMIT: cmd.commit   = 1'b1;
         ST_OUT:    cmd.out_load = status.out_free;
         default:   cmd          = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_IDLE;
      else
         state_ff <= state_in;
   end

endmodule

// ----- hdl/rdmc_datapath.sv -----
// Datapath of the carver: visited map (one row per word), path stack,
// neighbor evaluation and the output register. Depends on rdmc_pkg.
`timescale 1ns / 1ps

module rdmc_datapath
   import rdmc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output status_type             status,
   input  logic [RND_W-1:0]       req_random_value,
   input  logic [CFG_W-1:0]       grid_rows,
   input  logic [CFG_W-1:0]       grid_cols,
   input  logic                   rsp_tready,
   output logic                   rsp_tvalid,
   output logic                   rsp_carved,
   output logic [OUT_COORD_W-1:0] rsp_cell_row,
   output logic [OUT_COORD_W-1:0] rsp_cell_col,
   output logic [DIR_W-1:0]       rsp_direction,
   output logic                   rsp_finished
);

   // memories
   logic [MAX_COLS-1:0] visited_mem [MAX_ROWS];
   logic [CELL_W-1:0]   stack_mem   [CELL_COUNT];

   // memory read data
   logic [MAX_COLS-1:0] row_a_ff;
   logic [MAX_COLS-1:0] row_b_ff;
   logic [CELL_W-1:0]   stack_rd_ff;

   // control registers
   logic [DEPTH_W-1:0]  depth_ff, depth_in;
   logic [ROW_W-1:0]    clr_cnt_ff, clr_cnt_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;

   // payload registers
   logic [1:0]          rnd_lo_ff, rnd_lo_in;
   logic [1:0]          rnd_mod3_ff, rnd_mod3_in;
   logic [ROW_W-1:0]    cur_row_ff, cur_row_in;
   logic [COL_W-1:0]    cur_col_ff, cur_col_in;
   logic [MAX_COLS-1:0] north_ff, north_in;
   logic [MAX_COLS-1:0] south_ff, south_in;
   logic                carve_ff, carve_in;
   dir_type             dir_ff, dir_in;
   logic [ROW_W-1:0]    new_row_ff, new_row_in;
   logic [COL_W-1:0]    new_col_ff, new_col_in;
   logic [MAX_COLS-1:0] wr_row_ff, wr_row_in;
   logic                    out_carved_ff, out_carved_in;
   logic [OUT_COORD_W-1:0]  out_row_ff, out_row_in;
   logic [OUT_COORD_W-1:0]  out_col_ff, out_col_in;
   logic [DIR_W-1:0]        out_dir_ff, out_dir_in;
   logic                    out_fin_ff, out_fin_in;

   // memory port signals
   logic [ROW_W-1:0]    top_row;
   logic [COL_W-1:0]    top_col;
   logic                vis_rd_a_en, vis_rd_b_en, vis_we;
   logic [ROW_W-1:0]    vis_rd_a_addr, vis_rd_b_addr, vis_waddr;
   logic [MAX_COLS-1:0] vis_wdata;
   logic                stk_we;
   logic [CELL_W-1:0]   stk_raddr, stk_waddr, stk_wdata;
   logic [DEPTH_W-1:0]  depth_m1;
   logic                clr_first;
   logic                stack_has_room;

   // evaluation signals
   logic [SIZE_W-1:0]   rows_u, cols_u;
   logic [SIZE_W-1:0]   cur_r_ext, cur_c_ext;
   logic                at_end;
   logic                ok_n, ok_s, ok_w, ok_e;
   logic [3:0]          cand;
   logic [2:0]          cand_cnt;
   logic [1:0]          pick_k;
   dir_type             pick;
   logic [ROW_W-1:0]    nxt_row;
   logic [COL_W-1:0]    nxt_col;
   logic [MAX_COLS-1:0] base_row;

   assign top_row        = stack_rd_ff[CELL_W-1:COL_W];
   assign top_col        = stack_rd_ff[COL_W-1:0];
   assign depth_m1       = depth_ff - DEPTH_W'(1);
   assign clr_first      = (clr_cnt_ff == '0);
   assign stack_has_room = (depth_ff < DEPTH_W'(CELL_COUNT));

   // ---------------- neighbor evaluation ----------------
   assign rows_u    = used_size(grid_rows, MAX_ROWS);
   assign cols_u    = used_size(grid_cols, MAX_COLS);
   assign cur_r_ext = SIZE_W'(cur_row_ff);
   assign cur_c_ext = SIZE_W'(cur_col_ff);
   assign at_end    = (cur_r_ext == rows_u - SIZE_W'(1)) && (cur_c_ext == cols_u - SIZE_W'(1));

   // row_a_ff holds the cell's own row during evaluation
   assign ok_n = (cur_row_ff != '0) && !north_ff[cur_col_ff];
   assign ok_s = (cur_r_ext + SIZE_W'(1) < rows_u) && !south_ff[cur_col_ff];
   assign ok_w = (cur_col_ff != '0) && !row_a_ff[cur_col_ff - COL_W'(1)];
   assign ok_e = (cur_c_ext + SIZE_W'(1) < cols_u) && !row_a_ff[cur_col_ff + COL_W'(1)];

   assign cand     = at_end ? 4'b0000 : {ok_e, ok_w, ok_s, ok_n};
   assign cand_cnt = 3'($countones(cand));

   always_comb begin
      case (cand_cnt)
         3'd2:    pick_k = {1'b0, rnd_lo_ff[0]};
         3'd3:    pick_k = rnd_mod3_ff;
         3'd4:    pick_k = rnd_lo_ff;
         default: pick_k = 2'd0;
      endcase
   end

   assign pick = pick_dir(cand, pick_k);

   always_comb begin
      nxt_row  = cur_row_ff;
      nxt_col  = cur_col_ff;
      base_row = row_a_ff;
      case (pick)
         DIR_NORTH: begin
            nxt_row  = cur_row_ff - ROW_W'(1);
            base_row = north_ff;
         end
         DIR_SOUTH: begin
            nxt_row  = cur_row_ff + ROW_W'(1);
            base_row = south_ff;
         end
         DIR_WEST:  nxt_col = cur_col_ff - COL_W'(1);
         DIR_EAST:  nxt_col = cur_col_ff + COL_W'(1);
         default:   nxt_col = cur_col_ff;
      endcase
   end

   // ---------------- memory ports ----------------
   always_comb begin
      vis_rd_a_en   = cmd.rd_nbr || cmd.rd_cur;
      vis_rd_b_en   = cmd.rd_nbr;
      vis_rd_a_addr = cmd.rd_nbr ? (top_row - ROW_W'(1)) : cur_row_ff;
      vis_rd_b_addr = top_row + ROW_W'(1);

      vis_we    = cmd.clr_step || (cmd.commit && carve_ff);
      vis_waddr = cmd.clr_step ? clr_cnt_ff : new_row_ff;
      if (cmd.clr_step)
         vis_wdata = clr_first ? MAX_COLS'(1) : '0;  // start cell is visited
      else
         vis_wdata = wr_row_ff;

      stk_raddr = depth_m1[CELL_W-1:0];
      stk_we    = (cmd.clr_step && clr_first) || (cmd.commit && carve_ff && stack_has_room);
      stk_waddr = cmd.clr_step ? '0 : depth_ff[CELL_W-1:0];
      stk_wdata = cmd.clr_step ? '0 : {new_row_ff, new_col_ff};
   end

   always_ff @(posedge clock) begin
      if (vis_we)
         visited_mem[vis_waddr] <= vis_wdata;
      if (vis_rd_a_en)
         row_a_ff <= visited_mem[vis_rd_a_addr];
      if (vis_rd_b_en)
         row_b_ff <= visited_mem[vis_rd_b_addr];
   end

   always_ff @(posedge clock) begin
      if (stk_we)
         stack_mem[stk_waddr] <= stk_wdata;
      if (cmd.rd_top)
         stack_rd_ff <= stack_mem[stk_raddr];
   end

   // ---------------- next-state of registers ----------------
   always_comb begin
      depth_in      = depth_ff;
      clr_cnt_in    = clr_cnt_ff;
      rnd_lo_in     = rnd_lo_ff;
      rnd_mod3_in   = rnd_mod3_ff;
      cur_row_in    = cur_row_ff;
      cur_col_in    = cur_col_ff;
      north_in      = north_ff;
      south_in      = south_ff;
      carve_in      = carve_ff;
      dir_in        = dir_ff;
      new_row_in    = new_row_ff;
      new_col_in    = new_col_ff;
      wr_row_in     = wr_row_ff;

      if (cmd.accept) begin
         rnd_lo_in   = req_random_value[1:0];
         rnd_mod3_in = mod3_16(req_random_value);
         carve_in    = 1'b0;
         clr_cnt_in  = '0;
      end
      if (cmd.clr_step) begin
         clr_cnt_in = clr_cnt_ff + ROW_W'(1);
         if (clr_first)
            depth_in = DEPTH_W'(1);
      end
      if (cmd.rd_nbr) begin
         cur_row_in = top_row;
         cur_col_in = top_col;
      end
      if (cmd.rd_cur) begin
         north_in = row_a_ff;
         south_in = row_b_ff;
      end
      if (cmd.eval) begin
         carve_in   = (cand != 4'b0000);
         dir_in     = pick;
         new_row_in = nxt_row;
         new_col_in = nxt_col;
         wr_row_in  = base_row | (MAX_COLS'(1) << nxt_col);
      end
      if (cmd.commit) begin
         if (!carve_ff)
            depth_in = depth_m1;
         else if (stack_has_room)
            depth_in = depth_ff + DEPTH_W'(1);
      end
   end

   // output register
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      out_carved_in = out_carved_ff;
      out_row_in    = out_row_ff;
      out_col_in    = out_col_ff;
      out_dir_in    = out_dir_ff;
      out_fin_in    = out_fin_ff;
      if (rsp_tvalid_ff && rsp_tready)
         rsp_tvalid_in = 1'b0;
      if (cmd.out_load) begin
         rsp_tvalid_in = 1'b1;
         out_carved_in = carve_ff;
         out_row_in    = carve_ff ? OUT_COORD_W'(cur_row_ff) : '0;
         out_col_in    = carve_ff ? OUT_COORD_W'(cur_col_ff) : '0;
         out_dir_in    = carve_ff ? dir_ff : DIR_NORTH;
         out_fin_in    = (depth_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff      <= '0;
         clr_cnt_ff    <= '0;
         rsp_tvalid_ff <= 1'b0;
         carve_ff      <= 1'b0;
      end else begin
         depth_ff      <= depth_in;
         clr_cnt_ff    <= clr_cnt_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         carve_ff      <= carve_in;
      end
   end

   always_ff @(posedge clock) begin
      rnd_lo_ff     <= rnd_lo_in;
      rnd_mod3_ff   <= rnd_mod3_in;
      cur_row_ff    <= cur_row_in;
      cur_col_ff    <= cur_col_in;
      north_ff      <= north_in;
      south_ff      <= south_in;
      dir_ff        <= dir_in;
      new_row_ff    <= new_row_in;
      new_col_ff    <= new_col_in;
      wr_row_ff     <= wr_row_in;
      out_carved_ff <= out_carved_in;
      out_row_ff    <= out_row_in;
      out_col_ff    <= out_col_in;
      out_dir_ff    <= out_dir_in;
      out_fin_ff    <= out_fin_in;
   end

   assign status.stack_empty = (depth_ff == '0);
   assign status.clr_last    = (clr_cnt_ff == ROW_W'(MAX_ROWS - 1));
   assign status.out_free    = !rsp_tvalid_ff || rsp_tready;

   assign rsp_tvalid    = rsp_tvalid_ff;
   assign rsp_carved    = out_carved_ff;
   assign rsp_cell_row  = out_row_ff;
   assign rsp_cell_col  = out_col_ff;
   assign rsp_direction = out_dir_ff;
   assign rsp_finished  = out_fin_ff;

endmodule

// ----- hdl/rdmc_checker.sv -----
// Port-level checks for the maze carver, bound to the top level.
// Depends on rdmc_pkg and random_dfs_maze_carver_core.
`timescale 1ns / 1ps

module rdmc_checker
   import rdmc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [RND_W-1:0]      req_tdata,
   input logic                  req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser,
   input logic                  rsp_tlast,
   input logic                  csr_psel,
   input logic                  csr_penable,
   input logic                  csr_pwrite,
   input logic [CSR_ADDR_W-1:0] csr_paddr,
   input logic [CSR_DATA_W-1:0] csr_pwdata,
   input logic [CSR_DATA_W-1:0] csr_prdata,
   input logic                  csr_pready
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
                                    && $stable(rsp_tlast))
      else $error("stalled result item changed");

   // one item in work at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted while previous one in work");

   // a carved passage leaves a cell on the stack
   a_carve_not_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !rsp_tlast)
      else $error("carved result reports empty stack");

   // no passage means zero coordinates and direction
   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[RSP_FIELD_W-1:0] == '0)
      else $error("non-carving result has nonzero fields");

   // north passage never leaves from the top row
   a_north_row: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser && (rsp_tdata[RSP_FIELD_W-1:2*OUT_COORD_W] == DIR_NORTH)
      |-> rsp_tdata[OUT_COORD_W-1:0] != '0)
      else $error("north passage from row zero");

endmodule

bind random_dfs_maze_carver_core rdmc_checker u_rdmc_checker (.*);
